/* design/preemptive_priority_scheduler_assert.svh */
// Assertion macros for the preemptive priority scheduler.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define PPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

/* design/pps_pkg.sv */
// Shared types, constants and helpers for the preemptive priority scheduler.
package pps_pkg;

   localparam int SLOT_XW = 8;
   localparam int QDEPTH  = 2;
   localparam int QPW     = 1;
   localparam int QCW     = 2;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic        tick;
      logic        in_range;
      logic [2:0]  slot;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  prio;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_EXEC
   } sched_state_type;

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

/* design/preemptive_priority_scheduler.sv */
// Load transaction: written to the slot tables at the queue head. Tick transaction: SCAN,
// DRAIN, FETCH, EXEC to the result register (one slot scanned per cycle via the read port).
// A two-entry command queue takes new transactions while the back end works or stalls.
// One load per cycle while the back end is idle; a tick holds it until its result is registered.
// Reset clears time, running priority, ready flags and the queue and sets every finished
// flag; slot tables hold no value until loaded.
module preemptive_priority_scheduler
   import pps_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_burst_length,
   input  logic [7:0]  req_priority_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_running_slot,
   output logic [15:0] rsp_executed_ticks,
   output logic [15:0] rsp_time_now,
   output logic        rsp_idle,
   output logic        rsp_completed
);

`include "preemptive_priority_scheduler_assert.svh"

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   pps_front #(.SLOTS(SLOTS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_slot           (req_slot),
      .req_arrival_time   (req_arrival_time),
      .req_burst_length   (req_burst_length),
      .req_priority_level (req_priority_level),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop)
   );

   pps_back #(.SLOTS(SLOTS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_running_slot   (rsp_running_slot),
      .rsp_executed_ticks (rsp_executed_ticks),
      .rsp_time_now       (rsp_time_now),
      .rsp_idle           (rsp_idle),
      .rsp_completed      (rsp_completed)
   );

   `PPS_ASSERT_IMPL(a_idle_fields, clock, reset, rsp_valid && rsp_idle, (rsp_running_slot == 3'd0) && (rsp_executed_ticks == 16'd0) && !rsp_completed)
   `PPS_ASSERT_IMPL(a_done_ran, clock, reset, rsp_valid && rsp_completed, !rsp_idle && (rsp_executed_ticks != 16'd0))
   `PPS_ASSERT_IMPL(a_time_moved, clock, reset, rsp_valid, rsp_time_now != 16'd0)
   `PPS_ASSERT_IMPL(a_pop_has_cmd, clock, reset, !cmd_valid, !cmd_pop)
   `PPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

/* design/pps_front.sv */
// Front end: accepts transactions, classifies them and queues commands.
module pps_front
   import pps_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_burst_length,
   input  logic [7:0]  req_priority_level,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_pop
);

   cmd_type          q_ff [QDEPTH];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   cnt_ff, cnt_in;
   logic             push;
   logic             pop;
   cmd_type          new_cmd;

   assign req_ready = (cnt_ff != QCW'(QDEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      new_cmd.tick     = (req_func == FUNC_TICK);
      new_cmd.in_range = (SLOT_XW'(req_slot) < SLOT_XW'(SLOTS));
      new_cmd.slot     = req_slot;
      new_cmd.arrival  = req_arrival_time;
      new_cmd.burst    = req_burst_length;
      new_cmd.prio     = req_priority_level;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCW'(push) - QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

/* design/pps_back.sv */
// Back end: slot tables, one-slot-per-cycle ready scan, execution and result register.
module pps_back
   import pps_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_running_slot,
   output logic [15:0] rsp_executed_ticks,
   output logic [15:0] rsp_time_now,
   output logic        rsp_idle,
   output logic        rsp_completed
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   sched_state_type state_ff, state_in;
   logic [SW-1:0]   idx_ff, idx_in;
   logic            proc_vld_ff, proc_vld_in;
   logic [15:0]     time_ff, time_in;
   logic [7:0]      cur_prio_ff, cur_prio_in;
   logic [SW-1:0]   cur_slot_ff, cur_slot_in;
   logic [SLOTS-1:0] ready_ff, ready_in;
   logic [SLOTS-1:0] fin_ff, fin_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_slot_ff, rsp_slot_in;
   logic [15:0]     rsp_cnt_ff, rsp_cnt_in;
   logic [15:0]     rsp_time_ff, rsp_time_in;
   logic            rsp_idle_ff, rsp_idle_in;
   logic            rsp_done_ff, rsp_done_in;

   logic [15:0]     arr_mem [SLOTS];
   logic [15:0]     bur_mem [SLOTS];
   logic [7:0]      pri_mem [SLOTS];
   logic [15:0]     prg_mem [SLOTS];
   logic [15:0]     arr_rd_ff, bur_rd_ff, prg_rd_ff;
   logic [7:0]      pri_rd_ff;
   logic [SW-1:0]   rd_slot_ff;

   logic            out_free;
   logic            ld_en, ex_en, scan_rd;
   logic [SW-1:0]   rd_addr;
   logic [SLOT_XW-1:0] slot_x, cur_slot_x;
   logic [SW-1:0]   ld_idx;
   logic            scan_rdy;
   logic            run_idle;
   logic [15:0]     run_cnt;
   logic            run_done;
   logic            prg_we;
   logic [SW-1:0]   prg_addr;
   logic [15:0]     prg_data;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign slot_x     = SLOT_XW'(cmd.slot);
   assign cur_slot_x = SLOT_XW'(cur_slot_ff);
   assign ld_idx     = slot_x[SW-1:0];
   assign scan_rdy   = ready_ff[rd_slot_ff] || (!fin_ff[rd_slot_ff] && (arr_rd_ff <= time_ff));
   assign run_idle   = (cur_prio_ff == '0);
   assign run_cnt    = sat_inc16(prg_rd_ff);
   assign run_done   = !run_idle && (run_cnt >= bur_rd_ff);
   assign prg_we     = ld_en || (ex_en && !run_idle);
   assign prg_addr   = ld_en ? ld_idx : cur_slot_ff;
   assign prg_data   = ld_en ? 16'd0 : run_cnt;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.tick) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff == SW'(SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FETCH;
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      cmd_pop = 1'b0;
      ld_en   = 1'b0;
      ex_en   = 1'b0;
      scan_rd = 1'b0;
      rd_addr = cur_slot_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd_pop = cmd_valid;
            ld_en   = cmd_valid && !cmd.tick && cmd.in_range;
         end
         ST_SCAN: begin
            scan_rd = 1'b1;
            rd_addr = idx_ff;
         end
         ST_EXEC: ex_en = out_free;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      idx_in       = (state_ff == ST_SCAN) ? idx_ff + 1'b1 : '0;
      proc_vld_in  = scan_rd;
      time_in      = time_ff;
      cur_prio_in  = cur_prio_ff;
      cur_slot_in  = cur_slot_ff;
      ready_in     = ready_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_done_in  = rsp_done_ff;

      if (ld_en) begin
         ready_in[ld_idx] = 1'b0;
         fin_in[ld_idx]   = 1'b0;
         if (slot_x == cur_slot_x) begin
            cur_prio_in = '0;
         end
      end

      if (proc_vld_ff) begin
         ready_in[rd_slot_ff] = scan_rdy;
         if (scan_rdy && !fin_ff[rd_slot_ff] && (pri_rd_ff > cur_prio_ff)) begin
            cur_prio_in = pri_rd_ff;
            cur_slot_in = rd_slot_ff;
         end
      end

      if (ex_en) begin
         time_in      = sat_inc16(time_ff);
         rsp_valid_in = 1'b1;
         rsp_time_in  = sat_inc16(time_ff);
         rsp_idle_in  = run_idle;
         rsp_done_in  = run_done;
         rsp_slot_in  = run_idle ? 3'd0 : cur_slot_x[2:0];
         rsp_cnt_in   = run_idle ? 16'd0 : run_cnt;
         if (run_done) begin
            fin_in[cur_slot_ff]   = 1'b1;
            ready_in[cur_slot_ff] = 1'b0;
            cur_prio_in           = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         proc_vld_ff  <= 1'b0;
         time_ff      <= '0;
         cur_prio_ff  <= '0;
         cur_slot_ff  <= '0;
         ready_ff     <= '0;
         fin_ff       <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         proc_vld_ff  <= proc_vld_in;
         time_ff      <= time_in;
         cur_prio_ff  <= cur_prio_in;
         cur_slot_ff  <= cur_slot_in;
         ready_ff     <= ready_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_slot_ff <= rsp_slot_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_time_ff <= rsp_time_in;
      rsp_idle_ff <= rsp_idle_in;
      rsp_done_ff <= rsp_done_in;
   end

   // slot tables
   always_ff @(posedge clock) begin
      if (ld_en) begin
         arr_mem[ld_idx] <= cmd.arrival;
         bur_mem[ld_idx] <= cmd.burst;
         pri_mem[ld_idx] <= cmd.prio;
      end
      if (prg_we) begin
         prg_mem[prg_addr] <= prg_data;
      end
      arr_rd_ff  <= arr_mem[rd_addr];
      bur_rd_ff  <= bur_mem[rd_addr];
      pri_rd_ff  <= pri_mem[rd_addr];
      prg_rd_ff  <= prg_mem[rd_addr];
      rd_slot_ff <= rd_addr;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_running_slot   = rsp_slot_ff;
   assign rsp_executed_ticks = rsp_cnt_ff;
   assign rsp_time_now       = rsp_time_ff;
   assign rsp_idle           = rsp_idle_ff;
   assign rsp_completed      = rsp_done_ff;

endmodule

/* verif/tb_preemptive_priority_scheduler.sv */
// Self-checking testbench for the preemptive priority scheduler.
module tb_preemptive_priority_scheduler
   import pps_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS        = 8;
   localparam int RUN_LIMIT_NS = 2_000_000;

   typedef struct packed {
      logic [2:0]  slot;
      logic [15:0] ticks;
      logic [15:0] now;
      logic        idle;
      logic        done;
   } tick_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = FUNC_LOAD;
   logic [2:0]  req_slot = '0;
   logic [15:0] req_arrival_time = '0;
   logic [15:0] req_burst_length = '0;
   logic [7:0]  req_priority_level = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_running_slot;
   logic [15:0] rsp_executed_ticks;
   logic [15:0] rsp_time_now;
   logic        rsp_idle;
   logic        rsp_completed;

   // scheduler state as the testbench tracks it
   logic [15:0] arrival_tab  [SLOTS] = '{default: '0};
   logic [15:0] burst_tab    [SLOTS] = '{default: '0};
   logic [7:0]  prio_tab     [SLOTS] = '{default: '0};
   logic [15:0] progress_tab [SLOTS] = '{default: '0};
   bit          ready_tab    [SLOTS] = '{default: 1'b0};
   bit          finished_tab [SLOTS] = '{default: 1'b1};
   logic [15:0] clock_now = '0;
   logic [7:0]  run_prio = '0;
   logic [2:0]  run_slot = '0;

   tick_report_type tick_reports_due [$];
   tick_report_type report_want;
   tick_report_type report_new;
   int mismatch_count = 0;
   int sender_gap_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left = 0;

   preemptive_priority_scheduler #(.SLOTS(SLOTS)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_slot           (req_slot),
      .req_arrival_time   (req_arrival_time),
      .req_burst_length   (req_burst_length),
      .req_priority_level (req_priority_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_running_slot   (rsp_running_slot),
      .rsp_executed_ticks (rsp_executed_ticks),
      .rsp_time_now       (rsp_time_now),
      .rsp_idle           (rsp_idle),
      .rsp_completed      (rsp_completed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void load_slot_entry(input logic [2:0] s, input logic [15:0] arr,
                                           input logic [15:0] burst, input logic [7:0] prio);
      if (s < SLOTS) begin
         arrival_tab[s]  = arr;
         burst_tab[s]    = burst;
         prio_tab[s]     = prio;
         progress_tab[s] = '0;
         ready_tab[s]    = 1'b0;
         finished_tab[s] = 1'b0;
         if (run_slot == s)
            run_prio = '0;
      end
   endfunction

   function automatic tick_report_type schedule_tick();
      tick_report_type r;
      logic [15:0]  count;
      logic         done;
      logic         idle_now;
      count = '0;
      done  = 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
         if (!finished_tab[k] && arrival_tab[k] <= clock_now)
            ready_tab[k] = 1'b1;
      end
      for (int k = 0; k < SLOTS; k++) begin
         if (ready_tab[k] && !finished_tab[k] && prio_tab[k] > run_prio) begin
            run_prio = prio_tab[k];
            run_slot = k[2:0];
         end
      end
      idle_now  = (run_prio == 8'd0);
      clock_now = (clock_now == 16'hFFFF) ? clock_now : clock_now + 16'd1;
      if (!idle_now) begin
         if (progress_tab[run_slot] != 16'hFFFF)
            progress_tab[run_slot] = progress_tab[run_slot] + 16'd1;
         count = progress_tab[run_slot];
         if (count >= burst_tab[run_slot]) begin
            done = 1'b1;
            finished_tab[run_slot] = 1'b1;
            ready_tab[run_slot]    = 1'b0;
            run_prio = '0;
         end
      end
      r.slot  = idle_now ? 3'd0 : run_slot;
      r.ticks = idle_now ? 16'd0 : count;
      r.now   = clock_now;
      r.idle  = idle_now;
      r.done  = done;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (req_func == FUNC_LOAD) begin
            load_slot_entry(req_slot, req_arrival_time, req_burst_length, req_priority_level);
         end else begin
            report_new = schedule_tick();
            tick_reports_due.push_back(report_new);
         end
      end
   end

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (tick_reports_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: result transaction with none expected, actual slot %0d time %0d",
                     $time, rsp_running_slot, rsp_time_now);
         end else begin
            report_want = tick_reports_due.pop_front();
            compare_field("running_slot", 16'(report_want.slot), 16'(rsp_running_slot));
            compare_field("executed_ticks", report_want.ticks, rsp_executed_ticks);
            compare_field("time_now", report_want.now, rsp_time_now);
            compare_field("idle", 16'(report_want.idle), 16'(rsp_idle));
            compare_field("completed", 16'(report_want.done), 16'(rsp_completed));
         end
      end
   end

   // long hold-off takes priority over random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_request(input logic func, input logic [2:0] slot,
                               input logic [15:0] arr, input logic [15:0] burst,
                               input logic [7:0] prio);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_func           <= func;
      req_slot           <= slot;
      req_arrival_time   <= arr;
      req_burst_length   <= burst;
      req_priority_level <= prio;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic send_load(input logic [2:0] slot, input logic [15:0] arr,
                            input logic [15:0] burst, input logic [7:0] prio);
      send_request(FUNC_LOAD, slot, arr, burst, prio);
   endtask

   // unused payload fields get random values on ticks
   task automatic send_tick();
      send_request(FUNC_TICK, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
   endtask

   task automatic test_idle_ticks();
      repeat (2) send_tick();
   endtask

   task automatic test_single_process();
      send_load(3'd0, 16'd0, 16'd3, 8'd10);
      repeat (4) send_tick();
   endtask

   task automatic test_preemption_and_ties();
      send_load(3'd6, 16'd0, 16'd2, 8'd100);
      send_load(3'd4, 16'd0, 16'd2, 8'd100);
      send_load(3'd1, clock_now + 16'd2, 16'd1, 8'd255);
      repeat (6) send_tick();
   endtask

   task automatic test_special_cases();
      send_load(3'd7, 16'd0, 16'hFFFF, 8'hFF);
      repeat (2) send_tick();
      send_load(3'd7, 16'hFFFF, 16'd1, 8'd1);
      send_load(3'd5, 16'd0, 16'd5, 8'd0);
      send_load(3'd2, 16'd0, 16'd0, 8'd3);
      repeat (2) send_tick();
   endtask

   task automatic test_random_schedule(input int items, input int gap_pct, input int stall_pct);
      logic [16:0] near;
      logic [15:0] arr;
      logic [15:0] burst;
      logic [7:0]  prio;
      int          pick;
      sender_gap_pct = gap_pct;
      rsp_stall_pct  = stall_pct;
      repeat (items) begin
         if ($urandom_range(99) < 25) begin
            pick = $urandom_range(99);
            near = 17'(clock_now) + 17'($urandom_range(0, 5));
            if (pick < 65)
               arr = near[16] ? 16'hFFFF : near[15:0];
            else
               arr = 16'($urandom_range(0, 65535));
            pick = $urandom_range(99);
            if (pick < 72)
               burst = 16'($urandom_range(1, 10));
            else if (pick < 90)
               burst = 16'($urandom_range(11, 300));
            else if (pick < 98)
               burst = 16'($urandom_range(1, 65535));
            else
               burst = '0;
            pick = $urandom_range(99);
            if (pick < 45)
               prio = 8'($urandom_range(1, 255));
            else if (pick < 95)
               prio = 8'($urandom_range(1, 4));
            else
               prio = '0;
            send_load(3'($urandom_range(0, 7)), arr, burst, prio);
         end else begin
            send_tick();
         end
      end
   endtask

   task automatic test_backpressure();
      sender_gap_pct = 0;
      rsp_stall_pct  = 0;
      hold_left = 400;
      send_load(3'd1, clock_now, 16'd20, 8'd50);
      repeat (40) send_tick();
   endtask

   task automatic test_extreme_fields();
      sender_gap_pct = 0;
      rsp_stall_pct  = 0;
      for (int k = 0; k < SLOTS; k++) begin
         if (k == 3)
            send_load(k[2:0], 16'd0, 16'hFFFF, 8'hFF);
         else
            send_load(k[2:0], 16'd0, 16'd1, 8'd1);
      end
      send_load(3'd6, 16'hFFFF, 16'd1, 8'hFF);
      repeat (40) send_tick();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_idle_ticks();
      test_single_process();
      test_preemption_and_ties();
      test_special_cases();
      test_random_schedule(300, 0, 0);
      test_random_schedule(300, 45, 0);
      test_random_schedule(300, 0, 45);
      test_random_schedule(300, 11, 11);
      test_backpressure();
      test_extreme_fields();
      req_valid <= 1'b0;
      while (tick_reports_due.size() != 0)
         @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: run limit reached, %0d results outstanding", $time,
               tick_reports_due.size());
      $display("FAILURE");
      $finish;
   end

endmodule
